/* src/lart_pkg.sv */
// Shared constants for the longest alternating run tracker.
package lart_pkg;

  localparam int FIELD_W     = 11;    // width of position, length and run fields
  localparam int MAX_LEN_DEF = 1024;  // default capacity in bits
  localparam int LEN_RESET   = 1024;  // seq_length after reset (clipped to capacity)
  localparam int ADDR_W      = 3;     // register byte address width
  localparam int DATA_W      = 32;    // register data width
  localparam int REG_IDX_W   = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_SEQ_LENGTH = '0;

endpackage

/* src/longest_alternating_run_tracker.sv */
// Top level: bit-flip tracker with a RAM-held segment tree of alternating runs.
//
// Each accepted flip_position inverts one bit of a seq_length-bit sequence and returns the
// longest alternating run in the whole sequence. The segment tree lives in a single node
// RAM (one read, one write port). The flipped leaf lies at depth ceil(log2(seq_length)), or
// one less for some leaves when seq_length is not a power of two. The walk goes down the
// tree, reading each sibling on the way, writes the leaf and goes back up, one node write
// per cycle; the next item is taken only once the result has gone to the output register.
// A position of zero or above seq_length changes nothing, sets index_error and skips the
// tree walk. The result sits in an output register, so the next item is taken while a
// result still waits. After reset and after every write of seq_length the node RAM is swept
// to its initial contents, all 2*2^ceil(log2(MAX_LEN)) nodes (2048 by default) at one node
// per cycle, and no item is taken meanwhile. seq_length is at register address 0 and takes
// the low FIELD_W bits of the write; a value of 0 acts as 1 and one above MAX_LEN acts as
// MAX_LEN.
module longest_alternating_run_tracker
  import lart_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FIELD_W-1:0] flip_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] longest_run,
  output logic               index_error,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int LVL     = $clog2(MAX_LEN);
  localparam int NA_W    = LVL + 1;
  localparam int DEPTH   = 2 ** NA_W;
  localparam int DEP_W   = $clog2(LVL + 1);
  localparam int RST_LEN = (MAX_LEN < LEN_RESET) ? MAX_LEN : LEN_RESET;

  typedef struct packed {
    logic [CNT_W-1:0] best;
    logic [CNT_W-1:0] pre;
    logic [CNT_W-1:0] suf;
    logic             lbit;
    logic             rbit;
  } node_t;

  typedef struct packed {
    logic [NA_W-1:0]  node;
    logic             right;
    logic [CNT_W-1:0] lcnt;
    logic [CNT_W-1:0] rcnt;
  } path_t;

  typedef struct packed {
    path_t path;
    node_t sib;
  } frame_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DOWN,
    ST_LEAF,
    ST_UP,
    ST_RESP
  } state_t;

  localparam node_t NODE_INIT = '{best: CNT_W'(1), pre: CNT_W'(1), suf: CNT_W'(1),
                                  lbit: 1'b0, rbit: 1'b0};

  state_t           state;
  logic [NA_W-1:0]  clr_addr;
  logic [CNT_W-1:0] seq_length;
  logic [CNT_W-1:0] root_best;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [NA_W-1:0]  node;
  logic [DEP_W-1:0] depth;
  path_t            pend;
  logic             pend_valid;
  node_t            cur;
  logic [CNT_W-1:0] res_best;
  logic             res_err;
  frame_t           stk [LVL];

  logic             cfg_wr;
  logic [FIELD_W-1:0] wlen;
  logic [CNT_W-1:0] len_next;
  logic             in_err;
  logic             res_load;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] lcnt;
  logic [CNT_W-1:0] rcnt;
  logic             go_right;
  logic             at_leaf;
  logic [NA_W-1:0]  node_x2;
  node_t            leaf_new;
  node_t            lft;
  node_t            rgt;
  node_t            joined;
  node_t            rd_node;

  logic             ram_we;
  logic [NA_W-1:0]  ram_waddr;
  node_t            ram_wdata;
  logic             ram_re;
  logic [NA_W-1:0]  ram_raddr;
  logic [$bits(node_t)-1:0] ram_rdata;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_SEQ_LENGTH);
  assign wlen   = pwdata[FIELD_W-1:0];
  assign prdata = (paddr[ADDR_W-1:2] == REG_SEQ_LENGTH) ? DATA_W'(seq_length) : '0;

  always_comb begin
    if (wlen == '0) begin
      len_next = CNT_W'(1);
    end else if (32'(wlen) > 32'(MAX_LEN)) begin
      len_next = CNT_W'(MAX_LEN);
    end else begin
      len_next = CNT_W'(wlen);
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign in_err   = (flip_position == '0) || (32'(flip_position) > 32'(seq_length));
  assign res_load = (state == ST_RESP) && (!out_valid || out_ready);

  // Tree walk: split the current range
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CNT_W:1];
  assign lcnt     = mid - lo + CNT_W'(1);
  assign rcnt     = hi - mid;
  assign go_right = pos > mid;
  assign at_leaf  = (lo == hi);
  assign node_x2  = {node[NA_W-2:0], 1'b0};

  assign rd_node  = node_t'(ram_rdata);
  assign leaf_new = '{best: CNT_W'(1), pre: CNT_W'(1), suf: CNT_W'(1),
                      lbit: ~rd_node.rbit, rbit: ~rd_node.rbit};

  // Merge the freshly updated child with its sibling
  always_comb begin
    lft = stk[0].path.right ? stk[0].sib : cur;
    rgt = stk[0].path.right ? cur : stk[0].sib;
    joined.best = (lft.best > rgt.best) ? lft.best : rgt.best;
    joined.pre  = lft.pre;
    joined.suf  = rgt.suf;
    joined.lbit = lft.lbit;
    joined.rbit = rgt.rbit;
    if (lft.rbit != rgt.lbit) begin
      if (lft.suf + rgt.pre > joined.best) begin
        joined.best = lft.suf + rgt.pre;
      end
      if (lft.best == stk[0].path.lcnt) begin
        joined.pre = stk[0].path.lcnt + rgt.pre;
      end
      if (rgt.best == stk[0].path.rcnt) begin
        joined.suf = stk[0].path.rcnt + lft.suf;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = NODE_INIT;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      ST_DOWN: begin
        ram_re    = 1'b1;
        ram_raddr = at_leaf ? node : (node_x2 | NA_W'(!go_right));
      end
      ST_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = node;
        ram_wdata = leaf_new;
      end
      ST_UP: begin
        ram_we    = 1'b1;
        ram_waddr = stk[0].path.node;
        ram_wdata = joined;
      end
      default: begin
      end
    endcase
  end

  lart_ram #(
    .WIDTH($bits(node_t)),
    .DEPTH(DEPTH)
  ) u_node_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Path stack: push on the way down, pop on the way up
  always_ff @(posedge clk) begin
    if (state == ST_DOWN && pend_valid) begin
      stk[0] <= '{path: pend, sib: rd_node};
      for (int i = 1; i < LVL; i++) begin
        stk[i] <= stk[i-1];
      end
    end else if (state == ST_UP) begin
      for (int i = 0; i < LVL - 1; i++) begin
        stk[i] <= stk[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      seq_length <= CNT_W'(RST_LEN);
      root_best  <= CNT_W'(1);
      depth      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Output register: load a finished result, else drop a taken beat
      if (res_load) begin
        out_valid   <= 1'b1;
        longest_run <= FIELD_W'(res_best);
        index_error <= res_err;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        seq_length <= len_next;
        root_best  <= CNT_W'(1);
        clr_addr   <= '0;
        state      <= ST_CLEAR;
      end else begin
        unique case (state)
          ST_CLEAR: begin
            clr_addr <= clr_addr + NA_W'(1);
            if (clr_addr == '1) begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (in_valid) begin
              pos <= CNT_W'(flip_position);
              if (in_err) begin
                res_best <= root_best;
                res_err  <= 1'b1;
                state    <= ST_RESP;
              end else begin
                lo         <= CNT_W'(1);
                hi         <= seq_length;
                node       <= NA_W'(1);
                depth      <= '0;
                pend_valid <= 1'b0;
                res_err    <= 1'b0;
                state      <= ST_DOWN;
              end
            end
          end
          ST_DOWN: begin
            if (pend_valid) begin
              depth <= depth + DEP_W'(1);
            end
            if (at_leaf) begin
              pend_valid <= 1'b0;
              state      <= ST_LEAF;
            end else begin
              pend       <= '{node: node, right: go_right, lcnt: lcnt, rcnt: rcnt};
              pend_valid <= 1'b1;
              node       <= node_x2 | NA_W'(go_right);
              if (go_right) begin
                lo <= mid + CNT_W'(1);
              end else begin
                hi <= mid;
              end
            end
          end
          ST_LEAF: begin
            cur <= leaf_new;
            if (depth == '0) begin
              res_best  <= CNT_W'(1);
              root_best <= CNT_W'(1);
              state     <= ST_RESP;
            end else begin
              state <= ST_UP;
            end
          end
          ST_UP: begin
            cur   <= joined;
            depth <= depth - DEP_W'(1);
            if (depth == DEP_W'(1)) begin
              res_best  <= joined.best;
              root_best <= joined.best;
              state     <= ST_RESP;
            end
          end
          ST_RESP: begin
            // hold until the output register is free
            if (res_load) begin
              state <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> state == ST_CLEAR)
    else $error("length write did not start the clearing sweep");

  a_err_direct: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_err && !cfg_wr) |=> state == ST_RESP)
    else $error("out-of-range beat walked the tree");

  a_root_fits: assert property (@(posedge clk) disable iff (rst)
    root_best <= seq_length)
    else $error("longest run exceeds the sequence length");

  a_up_has_frame: assert property (@(posedge clk) disable iff (rst)
    state == ST_UP |-> depth != '0)
    else $error("tree ascent with an empty path stack");
`endif

endmodule

/* src/lart_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module lart_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sim/tb.sv */
// Testbench for the longest alternating run tracker: directed and random flips checked by a scoreboard.
`timescale 1ns / 100ps

module tb;
  import lart_pkg::*;

  localparam int REG_SPARE   = 1;      // unmapped register index, writes are dropped
  localparam int QUIET_LIMIT = 20000;  // cycles with no beat before the run is abandoned
  localparam int HOLD_CYCLES = 400;
  localparam int N_PHASES    = 18;
  localparam int PHASE_ITEMS = 90;

  typedef struct {
    logic [FIELD_W-1:0] longest_run;
    logic               index_error;
  } run_beat_t;

  // Keeps a copy of the bit sequence and the queue of runs the block should report.
  class flip_scoreboard;
    bit          seq_bits [MAX_LEN_DEF+1];
    int unsigned seq_len;
    run_beat_t   expected_q [$];
    int unsigned fail_count;

    function new();
      seq_len = (LEN_RESET < MAX_LEN_DEF) ? LEN_RESET : MAX_LEN_DEF;
      foreach (seq_bits[i]) seq_bits[i] = 1'b0;
      fail_count = 0;
    endfunction

    function void set_length(logic [DATA_W-1:0] value);
      int unsigned len;
      len = 32'(value[FIELD_W-1:0]);
      if (len == 0) len = 1;
      if (len > MAX_LEN_DEF) len = MAX_LEN_DEF;
      seq_len = len;
      foreach (seq_bits[i]) seq_bits[i] = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function int unsigned longest_now();
      int unsigned run, best;
      run = 1;
      best = 1;
      for (int i = 2; i <= seq_len; i++) begin
        run = (seq_bits[i] != seq_bits[i-1]) ? run + 1 : 1;
        if (run > best) best = run;
      end
      return best;
    endfunction

    function void note_flip(logic [FIELD_W-1:0] pos);
      run_beat_t exp_beat;
      exp_beat.index_error = (pos == 0 || pos > seq_len);
      if (!exp_beat.index_error) seq_bits[pos] = ~seq_bits[pos];
      exp_beat.longest_run = FIELD_W'(longest_now());
      expected_q.push_back(exp_beat);
    endfunction

    function void check_result(logic [FIELD_W-1:0] run, logic err);
      run_beat_t exp_beat;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: longest_run=%0d index_error=%0d", run, err);
        fail_count++;
        return;
      end
      exp_beat = expected_q.pop_front();
      if (run !== exp_beat.longest_run) begin
        $error("longest_run mismatch: expected %0d, actual %0d", exp_beat.longest_run, run);
        fail_count++;
      end
      if (err !== exp_beat.index_error) begin
        $error("index_error mismatch: expected %0d, actual %0d", exp_beat.index_error, err);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [FIELD_W-1:0] flip_position = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [FIELD_W-1:0] longest_run;
  logic               index_error;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [ADDR_W-1:0]  paddr         = '0;
  logic [DATA_W-1:0]  pwdata        = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  flip_scoreboard sb;
  int unsigned    idle_pct     = 0;
  int unsigned    stall_pct    = 0;
  bit             hold_request = 1'b0;

  int unsigned phase_len [N_PHASES] =
    '{1, 0, 2, 3, 1024, 5, 2047, 16, 33, 64, 1500, 100, 255, 512, 7, 31, 1024, 12};
  logic [FIELD_W-1:0] directed_pos [19] =
    '{1, 2, 3, 4, 1024, 1023, 1025, 0, 2047, 1536, 512, 513, 511, 3, 1024, 682, 341, 1, 1022};

  longest_alternating_run_tracker dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .flip_position(flip_position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .longest_run  (longest_run),
    .index_error  (index_error),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly steer bits toward an alternating pattern so long runs form, with noise on top.
  function automatic logic [FIELD_W-1:0] pick_position(bit parity);
    int unsigned len, roll, start, p;
    len = sb.seq_len;
    roll = $urandom_range(99);
    if (roll < 3) return '0;
    if (roll < 10) return FIELD_W'($urandom_range((1 << FIELD_W) - 1, len + 1));
    if (roll < 30) return FIELD_W'($urandom_range(len, 1));
    start = $urandom_range(len, 1);
    for (int k = 0; k < len; k++) begin
      p = (start + k - 1) % len + 1;
      if (sb.seq_bits[p] != ((p + parity) & 1)) return FIELD_W'(p);
    end
    return FIELD_W'(start);
  endfunction

  task automatic send_flip(input logic [FIELD_W-1:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    flip_position <= pos;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_flip(pos);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx << 2);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SEQ_LENGTH) sb.set_length(value);
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready) sb.check_result(longest_run, index_error);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
          (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bit parity;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed beats run at the length left by reset.
    foreach (directed_pos[i]) begin
      if (i == 12) begin
        drain_results();
        write_reg(REG_SPARE, 32'd3);  // dropped: sequence and length stay as they are
      end
      send_flip(directed_pos[i]);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      write_reg(REG_SEQ_LENGTH, phase_len[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      parity = $urandom_range(1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Back up the output while flips keep coming, so the input stalls.
        if (p == 4 && k == 10) hold_request = 1'b1;
        if (p == 9 && k == PHASE_ITEMS / 2) drain_results();
        send_flip(pick_position(parity));
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
